/* sv/lcdns_pkg.sv */
// shared types, codes and constants of the character lcd nibble sequencer
`timescale 1ns / 1ps

package lcdns_pkg;

    // command codes carried in the input tuser
    localparam logic [3:0] ACT_INIT      = 4'd0;
    localparam logic [3:0] ACT_DATA      = 4'd1;
    localparam logic [3:0] ACT_CLEAR     = 4'd2;
    localparam logic [3:0] ACT_HOME      = 4'd3;
    localparam logic [3:0] ACT_CURSOR    = 4'd4;
    localparam logic [3:0] ACT_OFF       = 4'd5;
    localparam logic [3:0] ACT_ON        = 4'd6;
    localparam logic [3:0] ACT_LIGHT_OFF = 4'd7;
    localparam logic [3:0] ACT_LIGHT_ON  = 4'd8;
    localparam logic [3:0] ACT_TOGGLE    = 4'd9;

    // register indexes on the configuration port
    localparam logic [2:0] REG_RESET    = 3'd0;
    localparam logic [2:0] REG_FUNC_SET = 3'd1;
    localparam logic [2:0] REG_DISP_OFF = 3'd2;
    localparam logic [2:0] REG_DISP_ON  = 3'd3;
    localparam logic [2:0] REG_CLEAR    = 3'd4;
    localparam logic [2:0] REG_ENTRY    = 3'd5;
    localparam logic [2:0] REG_HOME     = 3'd6;
    localparam logic [2:0] REG_CURSOR   = 3'd7;

    // kinds of queued command
    localparam logic [1:0] KIND_INIT  = 2'd0;
    localparam logic [1:0] KIND_BYTE  = 2'd1;
    localparam logic [1:0] KIND_LIGHT = 2'd2;

    // waits in 100 us units
    localparam logic [9:0] WAIT_NONE    = 10'd0;
    localparam logic [9:0] WAIT_SHORT   = 10'd1;
    localparam logic [9:0] WAIT_RESET   = 10'd2;
    localparam logic [9:0] WAIT_LONG    = 10'd20;
    localparam logic [9:0] WAIT_RESET1  = 10'd60;
    localparam logic [9:0] WAIT_POWERUP = 10'd1000;

    localparam logic [3:0] INIT_LAST_STEP = 4'd14;

    typedef struct packed {
        logic [7:0] reset_code;
        logic [7:0] function_set_code;
        logic [7:0] display_off_code;
        logic [7:0] display_on_code;
        logic [7:0] clear_code;
        logic [7:0] entry_mode_code;
        logic [7:0] home_code;
        logic [7:0] cursor_code;
    } cfg_regs_t;

    typedef struct packed {
        logic [1:0] kind;
        logic       select_data;
        logic [7:0] code;
        logic       long_wait;
        logic       light;
    } cmd_t;

    typedef struct packed {
        logic       strobe_res;
        logic       select_data;
        logic [3:0] nibble;
        logic       light;
        logic [9:0] wait_units;
        logic       last;
    } event_t;

    function automatic logic [7:0] row_base(input logic [1:0] row);
        logic [7:0] base;
        unique case (row)
            2'd0: base = 8'h00;
            2'd1: base = 8'h40;
            2'd2: base = 8'h14;
            2'd3: base = 8'h54;
            default: base = 8'h00;
        endcase
        return base;
    endfunction

endpackage

/* sv/char_lcd_nibble_sequencer.sv */
// top level of the character lcd nibble sequencer
`timescale 1ns / 1ps

//  channel   | direction | beat contents
//  ----------+-----------+---------------------------------------------------
//  s_axis    | in        | one display command (action in tuser)
//  m_axis    | out       | one pin event; tlast on the final event of a command
//  apb       | in/out    | eight 8-bit instruction code registers at 4*i
//
//  each accepted command yields 1 (backlight), 2 (byte commands) or 15 (init)
//  output beats, one per cycle while m_axis_tready does not stall the output, and an unused action code yields none;
//  the sequencer step counter sets that figure
//  a new command is taken every cycle while the queue has room, so intake
//  overlaps the run of the command before it
//  the output register stalls only on m_axis_tready; the queue stalls intake
//  reset restores the default codes, turns the backlight off and empties the queue

module char_lcd_nibble_sequencer
    import lcdns_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
)
(
    input  logic        clk,
    input  logic        rst_n,
    // command stream
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // data_byte[7:0], column[12:8], line[14:13], pad
    input  logic [3:0]  s_axis_tuser,   // action[3:0]
    // event stream
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // strobe_res[0], nibble[4:1], light[5], wait_units[15:6]
    output logic [0:0]  m_axis_tuser,   // select_data[0]
    output logic        m_axis_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    cfg_regs_t regs;
    cmd_t      push_cmd;
    cmd_t      head_cmd;
    logic      q_push;
    logic      q_pop;
    logic      q_not_full;
    logic      q_not_empty;
    event_t    out_event;

    lcdns_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .regs    (regs)
    );

    // intake: decode, cursor address, backlight tracking
    lcdns_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .action    (s_axis_tuser),
        .data_byte (s_axis_tdata[7:0]),
        .column    (s_axis_tdata[12:8]),
        .line      (s_axis_tdata[14:13]),
        .q_ready   (q_not_full),
        .q_push    (q_push),
        .q_cmd     (push_cmd)
    );

    lcdns_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_cmd  (push_cmd),
        .not_full  (q_not_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .head      (head_cmd)
    );

    // sequencer with registered output beat
    lcdns_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .regs      (regs),
        .q_valid   (q_not_empty),
        .q_cmd     (head_cmd),
        .q_pop     (q_pop),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_event (out_event)
    );

    assign m_axis_tdata = {out_event.wait_units, out_event.light,
                           out_event.nibble, out_event.strobe_res};
    assign m_axis_tuser = out_event.select_data;
    assign m_axis_tlast = out_event.last;

endmodule

/* sv/lcdns_regs.sv */
// apb register file holding the instruction codes
`timescale 1ns / 1ps

module lcdns_regs
    import lcdns_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    output cfg_regs_t   regs
);

    cfg_regs_t  regs_reg;
    cfg_regs_t  regs_next;
    logic [2:0] index;
    logic [7:0] rd_byte;
    logic       wr_en;

    assign pready = 1'b1;
    assign index  = paddr[4:2];
    assign wr_en  = psel && penable && pwrite;
    assign regs   = regs_reg;

    always_comb
    begin
        regs_next = regs_reg;
        if (wr_en)
        begin
            unique case (index)
                REG_RESET:    regs_next.reset_code        = pwdata[7:0];
                REG_FUNC_SET: regs_next.function_set_code = pwdata[7:0];
                REG_DISP_OFF: regs_next.display_off_code  = pwdata[7:0];
                REG_DISP_ON:  regs_next.display_on_code   = pwdata[7:0];
                REG_CLEAR:    regs_next.clear_code        = pwdata[7:0];
                REG_ENTRY:    regs_next.entry_mode_code   = pwdata[7:0];
                REG_HOME:     regs_next.home_code         = pwdata[7:0];
                REG_CURSOR:   regs_next.cursor_code       = pwdata[7:0];
                default:      regs_next = regs_reg;
            endcase
        end
    end

    always_comb
    begin
        unique case (index)
            REG_RESET:    rd_byte = regs_reg.reset_code;
            REG_FUNC_SET: rd_byte = regs_reg.function_set_code;
            REG_DISP_OFF: rd_byte = regs_reg.display_off_code;
            REG_DISP_ON:  rd_byte = regs_reg.display_on_code;
            REG_CLEAR:    rd_byte = regs_reg.clear_code;
            REG_ENTRY:    rd_byte = regs_reg.entry_mode_code;
            REG_HOME:     rd_byte = regs_reg.home_code;
            REG_CURSOR:   rd_byte = regs_reg.cursor_code;
            default:      rd_byte = 8'h00;
        endcase
    end

    assign prdata = {24'h000000, rd_byte};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            regs_reg.reset_code        <= 8'd48;
            regs_reg.function_set_code <= 8'd40;
            regs_reg.display_off_code  <= 8'd8;
            regs_reg.display_on_code   <= 8'd12;
            regs_reg.clear_code        <= 8'd1;
            regs_reg.entry_mode_code   <= 8'd6;
            regs_reg.home_code         <= 8'd2;
            regs_reg.cursor_code       <= 8'd128;
        end
        else
        begin
            regs_reg <= regs_next;
        end
    end

endmodule

/* sv/lcdns_front.sv */
// command intake: decodes a command and tracks the backlight level
`timescale 1ns / 1ps

module lcdns_front
    import lcdns_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  cfg_regs_t  regs,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic [3:0] action,
    input  logic [7:0] data_byte,
    input  logic [4:0] column,
    input  logic [1:0] line,
    input  logic       q_ready,
    output logic       q_push,
    output cmd_t       q_cmd
);

    logic       light_reg;
    logic       light_next;
    logic       accept;
    logic       known;
    logic [7:0] cursor_addr;

    assign in_ready    = q_ready;
    assign accept      = in_valid && q_ready;
    assign cursor_addr = regs.cursor_code | (8'(column) + row_base(line));

    always_comb
    begin
        known             = 1'b1;
        light_next        = light_reg;
        q_cmd.kind        = KIND_BYTE;
        q_cmd.select_data = 1'b0;
        q_cmd.code        = 8'h00;
        q_cmd.long_wait   = 1'b1;
        unique case (action)
            ACT_INIT:
            begin
                q_cmd.kind = KIND_INIT;
            end
            ACT_DATA:
            begin
                q_cmd.select_data = 1'b1;
                q_cmd.code        = data_byte;
                q_cmd.long_wait   = 1'b0;
            end
            ACT_CLEAR:  q_cmd.code = regs.clear_code;
            ACT_HOME:   q_cmd.code = regs.home_code;
            ACT_CURSOR: q_cmd.code = cursor_addr;
            ACT_OFF:    q_cmd.code = regs.display_off_code;
            ACT_ON:     q_cmd.code = regs.display_on_code;
            ACT_LIGHT_OFF:
            begin
                q_cmd.kind = KIND_LIGHT;
                light_next = 1'b0;
            end
            ACT_LIGHT_ON:
            begin
                q_cmd.kind = KIND_LIGHT;
                light_next = 1'b1;
            end
            ACT_TOGGLE:
            begin
                q_cmd.kind = KIND_LIGHT;
                light_next = ~light_reg;
            end
            default:
            begin
                // unused codes are dropped without a result
                known = 1'b0;
            end
        endcase
        q_cmd.light = light_next;
    end

    assign q_push = accept && known;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            light_reg <= 1'b0;
        end
        else if (accept)
        begin
            light_reg <= light_next;
        end
    end

endmodule

/* sv/lcdns_queue.sv */
// small command queue between intake and sequencer
`timescale 1ns / 1ps

module lcdns_queue
    import lcdns_pkg::*;
#(
    parameter int DEPTH = 2
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic not_full,
    input  logic pop,
    output logic not_empty,
    output cmd_t head
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    cmd_t          slots_reg [DEPTH];
    logic [AW-1:0] wr_ptr_reg;
    logic [AW-1:0] wr_ptr_next;
    logic [AW-1:0] rd_ptr_reg;
    logic [AW-1:0] rd_ptr_next;
    logic [CW-1:0] count_reg;
    logic [CW-1:0] count_next;

    assign not_full  = (count_reg != CW'(DEPTH));
    assign not_empty = (count_reg != '0);
    assign head      = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* sv/lcdns_back.sv */
// event sequencer: steps through a queued command, one pin event per beat
`timescale 1ns / 1ps

module lcdns_back
    import lcdns_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_regs_t regs,
    input  logic      q_valid,
    input  cmd_t      q_cmd,
    output logic      q_pop,
    output logic      out_valid,
    input  logic      out_ready,
    output event_t    out_event
);

    logic [3:0] step_reg;
    logic [3:0] step_next;
    logic       valid_reg;
    logic       valid_next;
    event_t     event_reg;
    event_t     ev;
    logic       advance;
    logic [7:0] init_byte;

    assign advance   = q_valid && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_event = event_reg;

    always_comb
    begin
        init_byte = regs.reset_code;
        ev        = '0;
        ev.light  = q_cmd.light;
        unique case (q_cmd.kind)
            KIND_INIT:
            begin
                ev.strobe_res = (step_reg != 4'd0);
                // pairs of nibbles after the 4-bit switch
                priority if (step_reg <= 4'd3)
                    init_byte = regs.reset_code;
                else if (step_reg <= 4'd6)
                    init_byte = regs.function_set_code;
                else if (step_reg <= 4'd8)
                    init_byte = regs.display_off_code;
                else if (step_reg <= 4'd10)
                    init_byte = regs.clear_code;
                else if (step_reg <= 4'd12)
                    init_byte = regs.entry_mode_code;
                else
                    init_byte = regs.display_on_code;
                // even steps from six on carry the low nibble
                if (step_reg >= 4'd5 && !step_reg[0])
                    ev.nibble = init_byte[3:0];
                else if (step_reg != 4'd0)
                    ev.nibble = init_byte[7:4];
                priority if (step_reg == 4'd0)
                    ev.wait_units = WAIT_POWERUP;
                else if (step_reg == 4'd1)
                    ev.wait_units = WAIT_RESET1;
                else if (step_reg <= 4'd3)
                    ev.wait_units = WAIT_RESET;
                else if (step_reg == 4'd10)
                    ev.wait_units = WAIT_LONG;
                else if (step_reg == 4'd4 || !step_reg[0])
                    ev.wait_units = WAIT_SHORT;
                else
                    ev.wait_units = WAIT_NONE;
                ev.last = (step_reg == INIT_LAST_STEP);
            end
            KIND_BYTE:
            begin
                ev.strobe_res  = 1'b1;
                ev.select_data = q_cmd.select_data;
                ev.nibble      = step_reg[0] ? q_cmd.code[3:0] : q_cmd.code[7:4];
                ev.wait_units  = (step_reg[0] && q_cmd.long_wait) ? WAIT_LONG : WAIT_NONE;
                ev.last        = step_reg[0];
            end
            default:
            begin
                // backlight change: one event without a strobe, carrying the new backlight level
                ev.last = 1'b1;
            end
        endcase
    end

    assign q_pop = advance && ev.last;

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = 1'b1;
            step_next  = ev.last ? 4'd0 : step_reg + 4'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= 4'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            event_reg <= ev;
        end
    end

endmodule

/* bench/char_lcd_nibble_sequencer_tb.sv */
// self-checking testbench for the character lcd nibble sequencer
`timescale 1ns / 1ps

module char_lcd_nibble_sequencer_tb;
    import lcdns_pkg::*;

    // one row of the directed command list
    typedef struct packed {
        logic [3:0] action;
        logic [7:0] dbyte;
        logic [4:0] col;
        logic [1:0] row;
        logic       typed;    // expectation written out by hand in exp_val
        logic [7:0] exp_val;  // instruction/data byte, or backlight level
    } dir_row_t;

    localparam int NUM_DIR        = 23;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int SETTLE_CYCLES  = 20;

    // ddram row start addresses
    localparam logic [7:0] ROW_OFFSET [4] = '{8'h00, 8'h40, 8'h14, 8'h54};

    logic        clk;
    logic        rst_n = 1'b0;

    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // data_byte[7:0], column[12:8], line[14:13], pad
    logic [3:0]  s_axis_tuser  = '0;   // action[3:0]

    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // strobe_res[0], nibble[4:1], light[5], wait_units[15:6]
    logic [0:0]  m_axis_tuser;         // select_data[0]
    logic        m_axis_tlast;

    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [4:0]  paddr   = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;

    // local copy of the block state used for prediction
    logic [7:0]  code_reg [8];
    logic        backlight_model;

    // pin events still owed by the block, oldest first
    event_t      lcd_events [$];
    int          mismatch_count = 0;

    // idling percentages of the current phase
    int          tx_idle_pct  = 0;
    int          rx_stall_pct = 0;

    dir_row_t    dir_table [NUM_DIR];

    char_lcd_nibble_sequencer u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    // hard stop in case the block hangs; the slowest legal run is far shorter
    initial
    begin
        #4ms;
        $display("TB_ERROR");
        $finish;
    end

    // append one event; light reflects the backlight after this command
    function automatic void push_event(logic strobe, logic rs, logic [3:0] nib,
                                       logic [9:0] wait_u);
        event_t ev;
        ev.strobe_res  = strobe;
        ev.select_data = strobe ? rs : 1'b0;
        ev.nibble      = strobe ? nib : 4'd0;
        ev.light       = backlight_model;
        ev.wait_units  = wait_u;
        ev.last        = 1'b0;
        lcd_events.push_back(ev);
    endfunction

    // a byte goes out upper nibble first; only the lower nibble carries the wait
    function automatic void push_byte(logic rs, logic [7:0] code, logic [9:0] wait_u);
        push_event(1'b1, rs, code[7:4], WAIT_NONE);
        push_event(1'b1, rs, code[3:0], wait_u);
    endfunction

    // expected pin events for one accepted command
    function automatic void predict_pin_events(logic [3:0] action, logic [7:0] dbyte,
                                               logic [4:0] col, logic [1:0] row);
        logic [7:0] addr;
        int         n_before;
        n_before = lcd_events.size();
        case (action)
            ACT_INIT:
            begin
                // power-up wait, three reset nibbles, switch to 4-bit, then setup bytes
                push_event(1'b0, 1'b0, 4'd0, WAIT_POWERUP);
                push_event(1'b1, 1'b0, code_reg[REG_RESET][7:4], WAIT_RESET1);
                push_event(1'b1, 1'b0, code_reg[REG_RESET][7:4], WAIT_RESET);
                push_event(1'b1, 1'b0, code_reg[REG_RESET][7:4], WAIT_RESET);
                push_event(1'b1, 1'b0, code_reg[REG_FUNC_SET][7:4], WAIT_SHORT);
                push_byte(1'b0, code_reg[REG_FUNC_SET], WAIT_SHORT);
                push_byte(1'b0, code_reg[REG_DISP_OFF], WAIT_SHORT);
                push_byte(1'b0, code_reg[REG_CLEAR], WAIT_LONG);
                push_byte(1'b0, code_reg[REG_ENTRY], WAIT_SHORT);
                push_byte(1'b0, code_reg[REG_DISP_ON], WAIT_SHORT);
            end
            ACT_DATA:   push_byte(1'b1, dbyte, WAIT_NONE);
            ACT_CLEAR:  push_byte(1'b0, code_reg[REG_CLEAR], WAIT_LONG);
            ACT_HOME:   push_byte(1'b0, code_reg[REG_HOME], WAIT_LONG);
            ACT_CURSOR:
            begin
                // column past the row end is used as given, sum wraps at 8 bits
                addr = code_reg[REG_CURSOR] | (8'(col) + ROW_OFFSET[row]);
                push_byte(1'b0, addr, WAIT_LONG);
            end
            ACT_OFF:    push_byte(1'b0, code_reg[REG_DISP_OFF], WAIT_LONG);
            ACT_ON:     push_byte(1'b0, code_reg[REG_DISP_ON], WAIT_LONG);
            ACT_LIGHT_OFF:
            begin
                backlight_model = 1'b0;
                push_event(1'b0, 1'b0, 4'd0, WAIT_NONE);
            end
            ACT_LIGHT_ON:
            begin
                backlight_model = 1'b1;
                push_event(1'b0, 1'b0, 4'd0, WAIT_NONE);
            end
            ACT_TOGGLE:
            begin
                backlight_model = ~backlight_model;
                push_event(1'b0, 1'b0, 4'd0, WAIT_NONE);
            end
            default: ;  // unused action codes produce nothing
        endcase
        if (lcd_events.size() > n_before)
            lcd_events[$].last = 1'b1;
    endfunction

    // expectation written out in the table: a byte command or a backlight level
    function automatic void push_typed(logic [3:0] action, logic [7:0] exp_val);
        case (action)
            ACT_LIGHT_OFF, ACT_LIGHT_ON, ACT_TOGGLE:
            begin
                backlight_model = exp_val[0];
                push_event(1'b0, 1'b0, 4'd0, WAIT_NONE);
            end
            ACT_DATA: push_byte(1'b1, exp_val, WAIT_NONE);
            default:  push_byte(1'b0, exp_val, WAIT_LONG);
        endcase
        lcd_events[$].last = 1'b1;
    endfunction

    // present one command beat, holding it until the block takes it
    task automatic send_cmd(logic [3:0] action, logic [7:0] dbyte, logic [4:0] col,
                            logic [1:0] row, logic typed, logic [7:0] exp_val);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= action;
        s_axis_tdata  <= {1'b0, row, col, dbyte};
        do
            @(posedge clk);
        while (!s_axis_tready);
        if (typed)
            push_typed(action, exp_val);
        else
            predict_pin_events(action, dbyte, col, row);
    endtask

    // configuration register write: setup cycle, then access cycle
    task automatic write_code(logic [2:0] idx, logic [7:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {$urandom_range(255) << 24 | $urandom_range(65535) << 8} | 32'(val);
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        code_reg[idx] = val;
    endtask

    // wait for every owed event, then let an ignored command settle
    task automatic drain;
        while (lcd_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // receiver side: random backpressure and in-order checking
    always @(posedge clk)
    begin
        event_t got;
        event_t want;
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.strobe_res  = m_axis_tdata[0];
            got.nibble      = m_axis_tdata[4:1];
            got.light       = m_axis_tdata[5];
            got.wait_units  = m_axis_tdata[15:6];
            got.select_data = m_axis_tuser[0];
            got.last        = m_axis_tlast;
            if (lcd_events.size() == 0)
            begin
                $error("unexpected event beat: tdata %h tuser %h tlast %b",
                       m_axis_tdata, m_axis_tuser, m_axis_tlast);
                mismatch_count++;
            end
            else
            begin
                want = lcd_events.pop_front();
                if (got.strobe_res !== want.strobe_res)
                begin
                    $error("strobe_res: expected %0d, got %0d", want.strobe_res, got.strobe_res);
                    mismatch_count++;
                end
                if (got.select_data !== want.select_data)
                begin
                    $error("select_data: expected %0d, got %0d",
                           want.select_data, got.select_data);
                    mismatch_count++;
                end
                if (got.nibble !== want.nibble)
                begin
                    $error("nibble: expected %0d, got %0d", want.nibble, got.nibble);
                    mismatch_count++;
                end
                if (got.light !== want.light)
                begin
                    $error("light: expected %0d, got %0d", want.light, got.light);
                    mismatch_count++;
                end
                if (got.wait_units !== want.wait_units)
                begin
                    $error("wait_units: expected %0d, got %0d", want.wait_units, got.wait_units);
                    mismatch_count++;
                end
                if (got.last !== want.last)
                begin
                    $error("last: expected %0d, got %0d", want.last, got.last);
                    mismatch_count++;
                end
            end
        end
    end

    // stimulus
    initial
    begin
        logic [3:0] action;
        logic [4:0] col;
        int         counted;
        int         pick;

        // defaults after reset, backlight off
        code_reg[REG_RESET]    = 8'd48;
        code_reg[REG_FUNC_SET] = 8'd40;
        code_reg[REG_DISP_OFF] = 8'd8;
        code_reg[REG_DISP_ON]  = 8'd12;
        code_reg[REG_CLEAR]    = 8'd1;
        code_reg[REG_ENTRY]    = 8'd6;
        code_reg[REG_HOME]     = 8'd2;
        code_reg[REG_CURSOR]   = 8'd128;
        backlight_model        = 1'b0;

        // directed commands; typed byte rows carry the instruction or data byte expected
        dir_table = '{
            '{ACT_LIGHT_ON,  8'h00, 5'd0,  2'd0, 1'b1, 8'h01},
            '{ACT_DATA,      8'h00, 5'd0,  2'd0, 1'b1, 8'h00},
            '{ACT_DATA,      8'hFF, 5'd31, 2'd3, 1'b1, 8'hFF},
            '{ACT_DATA,      8'hA5, 5'd0,  2'd0, 1'b1, 8'hA5},
            '{ACT_CLEAR,     8'h00, 5'd0,  2'd0, 1'b1, 8'h01},
            '{ACT_HOME,      8'h00, 5'd0,  2'd0, 1'b1, 8'h02},
            '{ACT_CURSOR,    8'h00, 5'd0,  2'd0, 1'b1, 8'h80},
            '{ACT_CURSOR,    8'h00, 5'd19, 2'd3, 1'b1, 8'hE7},
            // column past the end of the row
            '{ACT_CURSOR,    8'h00, 5'd31, 2'd3, 1'b1, 8'hF3},
            '{ACT_CURSOR,    8'h00, 5'd12, 2'd1, 1'b1, 8'hCC},
            '{ACT_CURSOR,    8'h00, 5'd7,  2'd2, 1'b1, 8'h9B},
            '{ACT_OFF,       8'h00, 5'd0,  2'd0, 1'b1, 8'h08},
            '{ACT_ON,        8'h00, 5'd0,  2'd0, 1'b1, 8'h0C},
            '{ACT_TOGGLE,    8'h00, 5'd0,  2'd0, 1'b1, 8'h00},
            '{ACT_TOGGLE,    8'h00, 5'd0,  2'd0, 1'b1, 8'h01},
            '{ACT_LIGHT_OFF, 8'h00, 5'd0,  2'd0, 1'b1, 8'h00},
            '{ACT_INIT,      8'h00, 5'd0,  2'd0, 1'b0, 8'h00},
            // unused action codes are dropped without output
            '{4'd10,         8'h5A, 5'd3,  2'd1, 1'b0, 8'h00},
            '{4'd15,         8'hFF, 5'd31, 2'd3, 1'b0, 8'h00},
            '{ACT_LIGHT_ON,  8'h00, 5'd0,  2'd0, 1'b1, 8'h01},
            '{ACT_INIT,      8'h00, 5'd0,  2'd0, 1'b0, 8'h00},
            '{ACT_DATA,      8'h5A, 5'd21, 2'd2, 1'b0, 8'h00},
            '{ACT_CURSOR,    8'h00, 5'd20, 2'd0, 1'b0, 8'h00}
        };

        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < NUM_DIR; i++)
            send_cmd(dir_table[i].action, dir_table[i].dbyte, dir_table[i].col,
                     dir_table[i].row, dir_table[i].typed, dir_table[i].exp_val);
        s_axis_tvalid <= 1'b0;

        // random phases: each with its own code set and idling pattern
        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            for (int r = 0; r < 8; r++)
            begin
                case (ph)
                    0:       write_code(3'(r), 8'h00);
                    1:       write_code(3'(r), 8'hFF);
                    default: write_code(3'(r), 8'($urandom_range(255)));
                endcase
            end
            psel    <= 1'b0;
            penable <= 1'b0;
            pwrite  <= 1'b0;
            case (ph)
                0:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    tx_idle_pct  = 86;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    tx_idle_pct  = 0;
                    rx_stall_pct = 86;
                end
                default:
                begin
                    tx_idle_pct  = 18;
                    rx_stall_pct = 18;
                end
            endcase

            counted = 0;
            while (counted < ITEMS_PER_PHASE)
            begin
                // init is long, so keep it rare; a few unused codes as noise
                pick = $urandom_range(99);
                if (pick < 5)
                    action = ACT_INIT;
                else if (pick < 10)
                    action = 4'($urandom_range(15, 10));
                else
                    action = 4'($urandom_range(9, 1));
                if ($urandom_range(99) < 80)
                    col = 5'($urandom_range(19));
                else
                    col = 5'($urandom_range(31, 20));
                send_cmd(action, 8'($urandom_range(255)), col, 2'($urandom_range(3)),
                         1'b0, 8'h00);
                if (action <= ACT_TOGGLE)
                    counted++;
            end
            s_axis_tvalid <= 1'b0;
        end

        drain();
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

/* sim.f */
sv/lcdns_pkg.sv
sv/lcdns_regs.sv
sv/lcdns_front.sv
sv/lcdns_queue.sv
sv/lcdns_back.sv
sv/char_lcd_nibble_sequencer.sv
bench/char_lcd_nibble_sequencer_tb.sv
